### sv/wildcard_pattern_matcher_macros.svh
// Assertion macros shared by the wildcard pattern matcher RTL.
// Expects signals named clk and rst in the scope that uses them.
`ifndef WILDCARD_PATTERN_MATCHER_MACROS_SVH
`define WILDCARD_PATTERN_MATCHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/wpm_pkg.sv
// Package for the wildcard pattern matcher: widths, codes, structs, compare helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wpm_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);
  localparam int CHAR_W      = 8;
  localparam int WORD_W      = 64;
  localparam int CHARS_PER_WORD = WORD_W / CHAR_W;
  localparam int LEN_W       = 5;
  localparam int POS_W       = 16;
  localparam int CNT_W       = 16;
  localparam int CFG_ADDR_W  = 2;

  localparam logic [CHAR_W-1:0] WILD_ANY   = 8'h25;  // '%'
  localparam logic [CHAR_W-1:0] WILD_DIGIT = 8'h23;  // '#'
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;
  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2,
    REG_CASE     = 2'd3
  } cfg_reg_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic              advance;
    logic              clear;
    logic [CHAR_W-1:0] text;     // already case folded
    logic              fold;
  } cell_ctl_t;

  // Per-byte result from the tally unit.
  typedef struct packed {
    logic             ends;
    logic [CNT_W-1:0] count;
    logic             found;
    logic [POS_W-1:0] first;
  } tally_res_t;

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                  input logic en);
    if (en && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CASE_DELTA;
    end
    return c;
  endfunction

  function automatic logic char_hit(input logic [CHAR_W-1:0] p,
                                    input logic [CHAR_W-1:0] t);
    return (p == t) || (p == WILD_ANY) ||
           ((p == WILD_DIGIT) && (t >= CH_ZERO) && (t <= CH_NINE));
  endfunction

endpackage

`default_nettype wire

### sv/wpm_if.sv
// Channel interfaces for the wildcard pattern matcher (text, result, config).
// Depends on wpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wpm_text_if;
  logic                       valid;
  logic                       ready;
  logic [wpm_pkg::CHAR_W-1:0] text_char;
  logic                       last_char;
  modport source (output valid, text_char, last_char, input ready);
  modport sink   (input valid, text_char, last_char, output ready);
endinterface

interface wpm_result_if;
  logic                      valid;
  logic                      ready;
  logic                      match_ends_here;
  logic [wpm_pkg::CNT_W-1:0] match_count;
  logic                      found_any;
  logic [wpm_pkg::POS_W-1:0] first_match_start;
  logic                      text_done;
  modport source (output valid, match_ends_here, match_count, found_any,
                  first_match_start, text_done, input ready);
  modport sink   (input valid, match_ends_here, match_count, found_any,
                  first_match_start, text_done, output ready);
endinterface

interface wpm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wpm_pkg::CFG_ADDR_W-1:0] addr;
  logic [wpm_pkg::WORD_W-1:0]     data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

### sv/wpm_cell.sv
// One matcher chain cell: holds one partial-match bit and tests one pattern char.
// Depends on wpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpm_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire wpm_pkg::cell_ctl_t         ctl,
  input  wire logic [wpm_pkg::CHAR_W-1:0] pat_char,
  input  wire logic                       enable,    // cell lies inside the length
  input  wire logic                       prev_bit,  // from the left neighbor
  output logic                            bit_q,
  output logic                            bit_next
);

  logic [wpm_pkg::CHAR_W-1:0] pat_folded;

  assign pat_folded = wpm_pkg::fold_char(pat_char, ctl.fold);
  assign bit_next   = prev_bit && enable && wpm_pkg::char_hit(pat_folded, ctl.text);

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_q <= 1'b0;
    end else if (ctl.advance) begin
      bit_q <= ctl.clear ? 1'b0 : bit_next;
    end
  end

endmodule

`default_nettype wire

### sv/wpm_tally.sv
// Match statistics: text position, saturating count, first match start.
// Depends on wpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpm_tally (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          advance,
  input  wire logic                          clear,
  input  wire logic                          ends,
  input  wire logic [wpm_pkg::PAT_IDX_W-1:0] len_m1,
  output wpm_pkg::tally_res_t                res
);

  logic [wpm_pkg::POS_W-1:0] pos;
  logic [wpm_pkg::CNT_W-1:0] count;
  logic                      found;
  logic [wpm_pkg::POS_W-1:0] first;
  logic [wpm_pkg::CNT_W-1:0] count_next;
  logic                      found_next;
  logic [wpm_pkg::POS_W-1:0] first_next;

  always_comb begin
    count_next = (ends && count != wpm_pkg::CNT_MAX) ? count + 1'b1 : count;
    found_next = found | ends;
    first_next = (ends && !found) ?
                 pos - wpm_pkg::POS_W'(len_m1) : first;
  end

  assign res = '{ends: ends, count: count_next, found: found_next, first: first_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      count <= '0;
      found <= 1'b0;
      first <= '0;
    end else if (advance) begin
      if (clear) begin
        pos   <= '0;
        count <= '0;
        found <= 1'b0;
        first <= '0;
      end else begin
        pos   <= pos + 1'b1;
        count <= count_next;
        found <= found_next;
        first <= first_next;
      end
    end
  end

endmodule

`default_nettype wire

### sv/wildcard_pattern_matcher.sv
// Top level of the wildcard pattern matcher: config registers, cell chain, tally, output reg.
// Depends on wpm_pkg, wpm_if, wpm_cell, wpm_tally and the macros header.
//
//  channel    role   payload                                           handshake
//  ---------  -----  ------------------------------------------------  -----------
//  text_in    sink   text_char[7:0], last_char                         valid/ready
//  result     source match_ends_here, match_count[15:0], found_any,    valid/ready
//                    first_match_start[15:0], text_done
//  cfg        sink   addr[1:0], data[63:0]                             valid/ready
//
//  Each text transaction yields one result transaction, valid in the cycle after it is taken.
//  One byte per cycle while results are taken: all cells compare in parallel, each passing its bit right.
//  text_in.ready is high while the result register is empty or being drained,
//  so only a result that is not taken holds text_in off. cfg.ready is always high.
//  Reset (rst, synchronous) clears partial bits, statistics and the result valid;
//  pattern registers reset to all zero, length 1, case fold off.
`timescale 1ns / 1ps
`default_nettype none
`include "wildcard_pattern_matcher_macros.svh"

module wildcard_pattern_matcher (
  input  wire logic clk,
  input  wire logic rst,
  wpm_text_if.sink     text_in,
  wpm_result_if.source result,
  wpm_cfg_if.sink      cfg
);

  localparam int NP = wpm_pkg::MAX_PATTERN;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [wpm_pkg::WORD_W-1:0]    pat_low;
  logic [wpm_pkg::WORD_W-1:0]    pat_high;
  logic [wpm_pkg::PAT_IDX_W-1:0] len_m1;     // effective length minus one
  logic                          case_fold;
  logic [wpm_pkg::LEN_W-1:0]     len_raw;
  logic [wpm_pkg::PAT_IDX_W-1:0] len_m1_next;

  assign cfg.ready = 1'b1;
  assign len_raw   = cfg.data[wpm_pkg::LEN_W-1:0];

  // Length 0 behaves as 1, anything past the chain as the full chain.
  always_comb begin
    if (len_raw == '0) begin
      len_m1_next = '0;
    end else if (len_raw > wpm_pkg::LEN_W'(NP)) begin
      len_m1_next = wpm_pkg::PAT_IDX_W'(NP - 1);
    end else begin
      len_m1_next = wpm_pkg::PAT_IDX_W'(len_raw - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low   <= '0;
      pat_high  <= '0;
      len_m1    <= '0;
      case_fold <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (wpm_pkg::cfg_reg_t'(cfg.addr))
        wpm_pkg::REG_PAT_LOW:  pat_low   <= cfg.data;
        wpm_pkg::REG_PAT_HIGH: pat_high  <= cfg.data;
        wpm_pkg::REG_PAT_LEN:  len_m1    <= len_m1_next;
        wpm_pkg::REG_CASE:     case_fold <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: one result register between the two sides
  // ---------------------------------------------------------------------------
  logic in_fire;
  logic out_valid;

  assign text_in.ready = !out_valid || result.ready;
  assign in_fire       = text_in.valid && text_in.ready;

  // ---------------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------------
  wpm_pkg::cell_ctl_t cell_ctl;
  logic [NP-1:0]      cell_bits;
  logic [NP-1:0]      cell_next;
  logic [NP-1:0]      cell_en;
  logic [2*wpm_pkg::WORD_W-1:0] pat_all;

  assign pat_all  = {pat_high, pat_low};
  assign cell_ctl = '{advance: in_fire,
                      clear:   text_in.last_char,
                      text:    wpm_pkg::fold_char(text_in.text_char, case_fold),
                      fold:    case_fold};

  for (genvar j = 0; j < NP; j++) begin : g_cell
    assign cell_en[j] = (wpm_pkg::PAT_IDX_W'(j) <= len_m1);
    wpm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (cell_ctl),
      .pat_char (pat_all[j*wpm_pkg::CHAR_W +: wpm_pkg::CHAR_W]),
      .enable   (cell_en[j]),
      .prev_bit ((j == 0) ? 1'b1 : cell_bits[(j == 0) ? 0 : j-1]),
      .bit_q    (cell_bits[j]),
      .bit_next (cell_next[j])
    );
  end

  // A match ends here when the cell for the last pattern char lights up.
  logic ends;
  assign ends = cell_next[len_m1];

  // ---------------------------------------------------------------------------
  // Statistics
  // ---------------------------------------------------------------------------
  wpm_pkg::tally_res_t tres;

  wpm_tally u_tally (
    .clk     (clk),
    .rst     (rst),
    .advance (in_fire),
    .clear   (text_in.last_char),
    .ends    (ends),
    .len_m1  (len_m1),
    .res     (tres)
  );

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic                      r_ends;
  logic [wpm_pkg::CNT_W-1:0] r_count;
  logic                      r_found;
  logic [wpm_pkg::POS_W-1:0] r_first;
  logic                      r_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      r_ends  <= tres.ends;
      r_count <= tres.count;
      r_found <= tres.found;
      r_first <= tres.first;
      r_done  <= text_in.last_char;
    end
  end

  assign result.valid             = out_valid;
  assign result.match_ends_here   = r_ends;
  assign result.match_count       = r_count;
  assign result.found_any         = r_found;
  assign result.first_match_start = r_first;
  assign result.text_done         = r_done;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `WPM_ASSERT_NEXT(a_clear_last, in_fire && text_in.last_char, cell_bits == '0, "not cleared")
  `WPM_ASSERT_NOW(a_match_found, out_valid && r_ends, r_found && r_count != '0, "match untallied")
  `WPM_ASSERT_NOW(a_stall_blocks, out_valid && !result.ready, !text_in.ready, "input not held")

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for wildcard_pattern_matcher: a directed table, then random
// texts, checked against a cycle-free predictor of the scan or hand-read table results.
// Depends on wpm_pkg, wpm_if and the wildcard_pattern_matcher RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int          SLOTS        = 16;        // pattern characters the block holds
  localparam int          RAND_ITEMS   = 1650;
  localparam int          HOLD_CYCLES  = 300;
  localparam int unsigned LIMIT_CYCLES = 200_000;

  // One result transaction as the predictor sees it.
  typedef struct packed {
    logic        ends;
    logic [15:0] count;
    logic        found;
    logic [15:0] first;
    logic        done;
  } scan_res_t;

  // One row of the directed table: a register write or a text byte.
  typedef struct packed {
    logic              cfg_row;
    wpm_pkg::cfg_reg_t reg_idx;
    logic [63:0]       wdata;
    logic [7:0]        ch;
    logic              last;
    logic              typed;     // want holds the expected result, read off by hand
    scan_res_t         want;
  } plan_row_t;

  typedef enum int {DRAIN_FULL, DRAIN_MOSTLY, DRAIN_PERIODIC, DRAIN_COIN} sink_mode_t;

  localparam scan_res_t NO_RES = '0;
  localparam int        PLAN_N = 29;

  localparam plan_row_t PLAN [PLAN_N] = '{
    // reset pattern is a single 0x00 character
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h00, 1'b0, 1'b1, '{1'b1, 16'd1, 1'b1, 16'd0, 1'b0}},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'hFF, 1'b1, 1'b1, '{1'b0, 16'd1, 1'b1, 16'd0, 1'b1}},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'hFF, 1'b1, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd0, 1'b1}},
    // "A%#z" folded
    '{1'b1, wpm_pkg::REG_PAT_LOW, 64'hFFFF_FFFF_7A23_2541, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b1, wpm_pkg::REG_PAT_LEN, 64'd4, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b1, wpm_pkg::REG_CASE, 64'd1, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h61, 1'b0, 1'b0, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h78, 1'b0, 1'b0, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h37, 1'b0, 1'b0, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h5A, 1'b0, 1'b0, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h41, 1'b0, 1'b0, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h25, 1'b0, 1'b0, NO_RES},  // literal wildcards
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h23, 1'b0, 1'b0, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h7A, 1'b1, 1'b0, NO_RES},
    // fold off, upper bits of the write set
    '{1'b1, wpm_pkg::REG_CASE, 64'hFFFF_FFFF_FFFF_FFFE, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h61, 1'b0, 1'b0, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h62, 1'b0, 1'b0, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h35, 1'b0, 1'b0, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h7A, 1'b0, 1'b0, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h41, 1'b0, 1'b0, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h2F, 1'b0, 1'b0, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h30, 1'b0, 1'b0, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h7A, 1'b1, 1'b0, NO_RES},
    // zero length acts as one
    '{1'b1, wpm_pkg::REG_PAT_LEN, 64'd0, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h41, 1'b1, 1'b1, '{1'b1, 16'd1, 1'b1, 16'd0, 1'b1}},
    // length 31 acts as 16; a two-byte text is too short to match
    '{1'b1, wpm_pkg::REG_PAT_HIGH, 64'h2525_2525_2525_2525, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b1, wpm_pkg::REG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h25, 1'b0, 1'b1, NO_RES},
    '{1'b0, wpm_pkg::REG_PAT_LOW, 64'd0, 8'h80, 1'b1, 1'b1, '{1'b0, 16'd0, 1'b0, 16'd0, 1'b1}}
  };

  logic clk;
  logic rst;

  wpm_text_if   text_if();
  wpm_result_if res_if();
  wpm_cfg_if    cfg_if();

  wildcard_pattern_matcher DUT (
    .clk     (clk),
    .rst     (rst),
    .text_in (text_if),
    .result  (res_if),
    .cfg     (cfg_if)
  );

  // Predictor copy of the registers and the scan state.
  logic [63:0] pat_lo;
  logic [63:0] pat_hi;
  logic [4:0]  pat_len;
  logic        fold_on;
  logic [15:0] partial;
  logic [15:0] pos;
  logic [15:0] tally;
  logic        found_flag;
  logic [15:0] first_pos;

  scan_res_t   pending_results[$];
  logic [8:0]  text_q[$];          // {last, byte} still to send
  int          mismatches;
  int          burst_left;
  bit          stall_request;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_scan();
    partial    = '0;
    pos        = '0;
    tally      = '0;
    found_flag = 1'b0;
    first_pos  = '0;
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] c);
    if (fold_on && c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
    return c;
  endfunction

  function automatic int eff_len();
    if (pat_len == 0) return 1;
    if (pat_len > SLOTS) return SLOTS;
    return int'(pat_len);
  endfunction

  // Advances the scan state by one text byte and returns the result it produces.
  function automatic scan_res_t scan_byte(input logic [7:0] raw, input logic last);
    scan_res_t    r;
    logic [7:0]   t;
    logic [7:0]   p;
    logic [15:0]  hits;
    logic [127:0] pat;
    int           n;
    t    = lower(raw);
    n    = eff_len();
    pat  = {pat_hi, pat_lo};
    hits = '0;
    for (int j = 0; j < n; j++) begin
      p = lower(pat[j*8 +: 8]);
      if (p == t || p == wpm_pkg::WILD_ANY ||
          (p == wpm_pkg::WILD_DIGIT && t >= 8'h30 && t <= 8'h39))
        hits[j] = 1'b1;
    end
    partial = {partial[14:0], 1'b1} & hits;
    r.ends  = partial[n-1];
    if (r.ends) begin
      if (tally != 16'hFFFF) tally++;
      if (!found_flag) begin
        found_flag = 1'b1;
        first_pos  = pos - 16'(n - 1);
      end
    end
    r.count = tally;
    r.found = found_flag;
    r.first = found_flag ? first_pos : '0;
    r.done  = last;
    pos = pos + 16'd1;
    if (last) clear_scan();
    return r;
  endfunction

  function automatic void cmp_field(input string name, input int unsigned want,
                                    input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Pattern character: wildcards, a few letters in both cases, digits, any byte.
  function automatic logic [7:0] pick_char(input bit wild_ok);
    case ($urandom_range(0, 9)) inside
      [0:1]:   return wild_ok ? wpm_pkg::WILD_ANY : 8'h61;
      2:       return wild_ok ? wpm_pkg::WILD_DIGIT : 8'h62;
      [3:4]:   return 8'h61 + 8'($urandom_range(0, 2));
      5:       return 8'h41 + 8'($urandom_range(0, 2));
      [6:7]:   return 8'h30 + 8'($urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // A text byte that the given pattern character accepts.
  function automatic logic [7:0] plant(input logic [7:0] p);
    if (p == wpm_pkg::WILD_ANY) return 8'($urandom_range(0, 255));
    if (p == wpm_pkg::WILD_DIGIT)
      return ($urandom_range(0, 4) == 0) ? wpm_pkg::WILD_DIGIT
                                         : 8'h30 + 8'($urandom_range(0, 9));
    if (fold_on && ((p >= 8'h41 && p <= 8'h5A) || (p >= 8'h61 && p <= 8'h7A)))
      return p ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
    return p;
  endfunction

  // Queues one text: mostly planted windows, some cut short, and noise bytes.
  task automatic build_text();
    int           n;
    int           k;
    int           m;
    int           eff;
    logic [7:0]   b;
    logic [8:0]   tail;
    logic [127:0] pat;
    n   = $urandom_range(1, 48);
    eff = eff_len();
    pat = {pat_hi, pat_lo};
    k   = 0;
    while (k < n) begin
      if ($urandom_range(0, 2) != 0) begin
        m = ($urandom_range(0, 3) == 0) ? $urandom_range(0, eff - 1) : eff;
        for (int j = 0; j < m; j++) begin
          text_q.push_back({1'b0, plant(pat[j*8 +: 8])});
          k++;
        end
      end
      b = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : pick_char(1'b0);
      text_q.push_back({1'b0, b});
      k++;
    end
    tail = text_q.pop_back();
    text_q.push_back({1'b1, tail[7:0]});
  endtask

  // Offers one byte; the sender sometimes idles between bursts of random length.
  task automatic send_byte(input logic [7:0] ch, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        text_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    text_if.valid     <= 1'b1;
    text_if.text_char <= ch;
    text_if.last_char <= last;
    do @(posedge clk); while (!(text_if.valid && text_if.ready));
  endtask

  task automatic feed(input logic [7:0] ch, input logic last);
    send_byte(ch, last);
    pending_results.push_back(scan_byte(ch, last));
  endtask

  // Stops the text side and waits for every outstanding result transaction.
  task automatic settle();
    text_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(input wpm_pkg::cfg_reg_t idx, input logic [63:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    case (idx)
      wpm_pkg::REG_PAT_LOW:  pat_lo  = val;
      wpm_pkg::REG_PAT_HIGH: pat_hi  = val;
      wpm_pkg::REG_PAT_LEN:  pat_len = val[4:0];
      wpm_pkg::REG_CASE:     fold_on = val[0];
      default:      ;
    endcase
    @(posedge clk);
  endtask

  // New setting per phase: phase 1 all-zero pattern, phase 2 all-ones, the others shaped.
  task automatic retune(input int ph);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] lenw;
    int          r;
    for (int k = 0; k < 8; k++) begin
      lo[k*8 +: 8] = pick_char(1'b1);
      hi[k*8 +: 8] = pick_char(1'b1);
    end
    if (ph == 1) begin
      lo = '0;
      hi = '0;
    end
    if (ph == 2) begin
      lo = '1;
      hi = '1;
    end
    lenw = {$urandom, $urandom};
    r = $urandom_range(0, 9);
    // mostly short patterns; out-of-range lengths now and then
    if (r == 0)      lenw[4:0] = 5'd0;
    else if (r == 1) lenw[4:0] = 5'($urandom_range(17, 31));
    else if (r == 2) lenw[4:0] = 5'd16;
    else if (r < 5)  lenw[4:0] = 5'($urandom_range(5, 15));
    else             lenw[4:0] = 5'($urandom_range(1, 4));
    write_reg(wpm_pkg::REG_PAT_LOW, lo);
    write_reg(wpm_pkg::REG_PAT_HIGH, hi);
    write_reg(wpm_pkg::REG_PAT_LEN, lenw);
    write_reg(wpm_pkg::REG_CASE, {$urandom, $urandom});
  endtask

  // Result side: changes stall behavior every so often; a stall request makes it drop
  // ready and hold off, so the result register fills and text_in backs up.
  initial begin : result_sink
    sink_mode_t mode;
    int         span;
    int         tick;
    res_if.ready <= 1'b0;
    mode = DRAIN_FULL;
    span = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (span == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        span = $urandom_range(8, 200);
      end
      span--;
      tick++;
      case (mode)
        DRAIN_FULL:     res_if.ready <= 1'b1;
        DRAIN_MOSTLY:   res_if.ready <= ($urandom_range(0, 3) != 0);
        DRAIN_PERIODIC: res_if.ready <= ((tick % 5) < 3);
        default:        res_if.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Every accepted result transaction is checked against the oldest expectation.
  always @(posedge clk) begin : result_check
    scan_res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expected result pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        cmp_field("match_ends_here", want.ends, res_if.match_ends_here);
        cmp_field("match_count", want.count, res_if.match_count);
        cmp_field("found_any", want.found, res_if.found_any);
        cmp_field("first_match_start", want.first, res_if.first_match_start);
        cmp_field("text_done", want.done, res_if.text_done);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL wildcard_pattern_matcher");
    $finish;
  end

  initial begin : stimulus
    int         ph;
    int         sent;
    int         n;
    logic [8:0] nxt;

    rst               <= 1'b1;
    text_if.valid     <= 1'b0;
    text_if.text_char <= '0;
    text_if.last_char <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.addr       <= wpm_pkg::REG_PAT_LOW;
    cfg_if.data       <= '0;
    stall_request = 1'b0;
    mismatches    = 0;
    burst_left    = 0;
    pat_lo  = '0;
    pat_hi  = '0;
    pat_len = 5'd1;
    fold_on = 1'b0;
    clear_scan();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    for (int i = 0; i < PLAN_N; i++) begin
      if (PLAN[i].cfg_row) begin
        settle();
        write_reg(PLAN[i].reg_idx, PLAN[i].wdata);
      end else if (PLAN[i].typed) begin
        send_byte(PLAN[i].ch, PLAN[i].last);
        void'(scan_byte(PLAN[i].ch, PLAN[i].last));
        pending_results.push_back(PLAN[i].want);
      end else begin
        feed(PLAN[i].ch, PLAN[i].last);
      end
    end

    // Random phases; a text may still be open when the registers change.
    ph   = 0;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      settle();
      retune(ph);
      if (ph == 0) stall_request = 1'b1;
      n = $urandom_range(60, 200);
      repeat (n) begin
        if (text_q.size() == 0) build_text();
        nxt = text_q.pop_front();
        feed(nxt[7:0], nxt[8]);
        sent++;
      end
      ph++;
    end
    while (text_q.size() != 0) begin
      nxt = text_q.pop_front();
      feed(nxt[7:0], nxt[8]);
    end

    settle();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS wildcard_pattern_matcher");
    end else begin
      $display("FAIL wildcard_pattern_matcher");
    end
    $finish;
  end

endmodule
